FILE: hw/rtl/dq_pkg.sv
// package for the double-ended queue: request and status codes, shared types
// and sizing constants; no dependencies

package dq_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned FILL_W    = 7;
  localparam int unsigned STAT_W    = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic latch_req;
    logic exec;
    logic rd;
    logic load_out;
  } dq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dq_stat_t;

endpackage

FILE: hw/rtl/dq_ctrl.sv
// controller for the double-ended queue: sequences accept, update, read and
// result load; uses dq_pkg

module dq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dq_pkg::dq_stat_t stat_i,
  output dq_pkg::dq_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_FIN;
      end
      S_FIN: begin
        // hold until the result register can take the word
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/dq_datapath.sv
// datapath for the double-ended queue: ring store, head/tail/count registers
// and the result register; uses dq_pkg

module dq_datapath #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dq_pkg::dq_cmd_t                  cmd_i,
  output dq_pkg::dq_stat_t                 stat_o,
  input  logic        [dq_pkg::REQ_W-1:0]  req_type_i,
  input  logic signed [dq_pkg::DATA_W-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [dq_pkg::DATA_W-1:0] front_value_o,
  output logic signed [dq_pkg::DATA_W-1:0] back_value_o,
  output logic        [dq_pkg::FILL_W-1:0] fill_count_o,
  output logic                             is_empty_o,
  output logic        [dq_pkg::STAT_W-1:0] status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [dq_pkg::DATA_W-1:0] mem [DEPTH];

  logic [dq_pkg::REQ_W-1:0]  req_q;
  logic [dq_pkg::DATA_W-1:0] val_q;
  logic [AW-1:0]             head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]             count_q, count_d;
  logic [dq_pkg::STAT_W-1:0] st_q, st_d;
  logic [dq_pkg::DATA_W-1:0] rd_f_q, rd_b_q;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             head_inc, head_dec, tail_inc, tail_dec;
  logic                      full, empty;
  logic                      out_valid_q;

  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
  assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
  assign tail_dec = (tail_q == '0) ? LAST_IDX : tail_q - AW'(1);
  assign full     = (count_q == FULL_CNT);
  assign empty    = (count_q == '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    st_d    = dq_pkg::ST_DONE;
    we      = 1'b0;
    waddr   = tail_q;
    case (req_q)
      dq_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          st_d = dq_pkg::ST_FULL;
        end else begin
          we      = 1'b1;
          waddr   = tail_q;
          tail_d  = tail_inc;
          count_d = count_q + CW'(1);
        end
      end
      dq_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          st_d = dq_pkg::ST_FULL;
        end else begin
          we      = 1'b1;
          waddr   = head_dec;
          head_d  = head_dec;
          count_d = count_q + CW'(1);
        end
      end
      dq_pkg::REQ_POP_BACK: begin
        if (empty) begin
          st_d = dq_pkg::ST_EMPTY;
        end else begin
          tail_d  = tail_dec;
          count_d = count_q - CW'(1);
        end
      end
      dq_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          st_d = dq_pkg::ST_EMPTY;
        end else begin
          head_d  = head_inc;
          count_d = count_q - CW'(1);
        end
      end
      default: st_d = dq_pkg::ST_DONE; // peek and unused codes
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q <= req_type_i;
      val_q <= value_i;
    end
  end

  // ring store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem[waddr] <= val_q;
    end
    if (cmd_i.rd) begin
      rd_f_q <= mem[head_q];
      rd_b_q <= mem[tail_dec];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      st_q    <= dq_pkg::ST_DONE;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      st_q    <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      front_value_o <= empty ? '0 : $signed(rd_f_q);
      back_value_o  <= empty ? '0 : $signed(rd_b_q);
      fill_count_o  <= dq_pkg::FILL_W'(count_q);
      is_empty_o    <= empty;
      status_o      <= st_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

FILE: hw/rtl/double_ended_queue.sv
// double-ended queue top level: one request word in, one result word out
// requests are taken one at a time: the next only once the previous result is loaded into the result register
// a new request is taken while the previous result still waits on the output
// reset (rst_ni low, asynchronous) empties the queue; the store itself is not cleared
// depends on dq_pkg, dq_ctrl, dq_datapath

module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic        [dq_pkg::REQ_W-1:0]  req_type_i,
  input  logic signed [dq_pkg::DATA_W-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [dq_pkg::DATA_W-1:0] front_value_o,
  output logic signed [dq_pkg::DATA_W-1:0] back_value_o,
  output logic        [dq_pkg::FILL_W-1:0] fill_count_o,
  output logic                             is_empty_o,
  output logic        [dq_pkg::STAT_W-1:0] status_o
);

  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .fill_count_o  (fill_count_o),
    .is_empty_o    (is_empty_o),
    .status_o      (status_o)
  );

endmodule

FILE: hw/rtl/dq_checker.sv
// port-level checks for the double-ended queue, bound to the top level
// depends on dq_pkg

module dq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic        [dq_pkg::REQ_W-1:0]  req_type_i,
  input logic signed [dq_pkg::DATA_W-1:0] value_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [dq_pkg::DATA_W-1:0] front_value_o,
  input logic signed [dq_pkg::DATA_W-1:0] back_value_o,
  input logic        [dq_pkg::FILL_W-1:0] fill_count_o,
  input logic                             is_empty_o,
  input logic        [dq_pkg::STAT_W-1:0] status_o
);

  // request word holds while it waits to be taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      (in_valid_i && $stable(req_type_i) && $stable(value_i)))
    else $error("request word changed while waiting");

  // empty flag agrees with the count
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (fill_count_o == '0)))
    else $error("empty flag disagrees with fill count");

  // an empty queue shows zero at both ends
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (front_value_o == '0 && back_value_o == '0))
    else $error("empty queue shows nonzero end value");

  // a dropped push leaves a full, hence nonempty, queue; an ignored pop an empty one
  a_status_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o != dq_pkg::ST_FULL || !is_empty_o) &&
                     (status_o != dq_pkg::ST_EMPTY || is_empty_o)))
    else $error("status code inconsistent with queue state");

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(front_value_o) && $stable(back_value_o) &&
       $stable(fill_count_o) && $stable(status_o)))
    else $error("result word changed while stalled");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .req_type_i    (req_type_i),
  .value_i       (value_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .front_value_o (front_value_o),
  .back_value_o  (back_value_o),
  .fill_count_o  (fill_count_o),
  .is_empty_o    (is_empty_o),
  .status_o      (status_o)
);

FILE: dv/tb.sv
// testbench for double_ended_queue: directed table then segmented random traffic, every result word checked
// against the table's expected word or a ring-store predictor; depends on dq_pkg and the rtl

module tb;

  localparam int unsigned QDEPTH = dq_pkg::DEPTH_DEF;
  localparam int unsigned IDX_W  = $clog2(QDEPTH);
  localparam int unsigned N_RAND = 1080;

  // request codes the block treats as a plain peek
  localparam logic [dq_pkg::REQ_W-1:0] REQ_UNKNOWN_A = 3'd5;
  localparam logic [dq_pkg::REQ_W-1:0] REQ_UNKNOWN_B = 3'd6;
  localparam logic [dq_pkg::REQ_W-1:0] REQ_UNKNOWN_C = 3'd7;

  localparam logic signed [dq_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [dq_pkg::DATA_W-1:0] VAL_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [dq_pkg::DATA_W-1:0] front;
    logic signed [dq_pkg::DATA_W-1:0] back;
    logic        [dq_pkg::FILL_W-1:0] fill;
    logic                             empty;
    logic        [dq_pkg::STAT_W-1:0] status;
  } dq_result_t;

  typedef struct packed {
    logic        [dq_pkg::REQ_W-1:0]  req;
    logic signed [dq_pkg::DATA_W-1:0] value;
    logic                             typed;
    dq_result_t                       want;
  } dir_row_t;

  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_NOISE} traffic_mode_e;

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_ready_o;
  logic        [dq_pkg::REQ_W-1:0]  req_type_i  = dq_pkg::REQ_PEEK;
  logic signed [dq_pkg::DATA_W-1:0] value_i     = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b1;
  logic signed [dq_pkg::DATA_W-1:0] front_value_o;
  logic signed [dq_pkg::DATA_W-1:0] back_value_o;
  logic        [dq_pkg::FILL_W-1:0] fill_count_o;
  logic                             is_empty_o;
  logic        [dq_pkg::STAT_W-1:0] status_o;

  double_ended_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .front_value_o(front_value_o),
    .back_value_o (back_value_o),
    .fill_count_o (fill_count_o),
    .is_empty_o   (is_empty_o),
    .status_o     (status_o)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic signed [dq_pkg::DATA_W-1:0] ring [QDEPTH];
  logic        [IDX_W-1:0]          head_q = '0;
  logic        [IDX_W-1:0]          tail_q = '0;
  int unsigned                      count_q = 0;

  dq_result_t  pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned words_sent     = 0;
  int unsigned full_drops     = 0;
  int unsigned empty_pops     = 0;
  int unsigned peak_fill      = 0;
  bit          calm           = 1'b0;

  function automatic logic [IDX_W-1:0] idx_inc(logic [IDX_W-1:0] i);
    return (i + 1 >= QDEPTH) ? '0 : IDX_W'(i + 1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(logic [IDX_W-1:0] i);
    return (i == 0) ? IDX_W'(QDEPTH - 1) : IDX_W'(i - 1);
  endfunction

  function automatic dq_result_t apply_request(logic [dq_pkg::REQ_W-1:0] req,
                                               logic signed [dq_pkg::DATA_W-1:0] val);
    dq_result_t r;
    r = '0;
    r.status = dq_pkg::ST_DONE;
    case (req)
      dq_pkg::REQ_PUSH_BACK, dq_pkg::REQ_PUSH_FRONT: begin
        if (count_q >= QDEPTH) begin
          r.status = dq_pkg::ST_FULL;
          full_drops++;
        end else if (req == dq_pkg::REQ_PUSH_BACK) begin
          ring[tail_q] = val;
          tail_q = idx_inc(tail_q);
          count_q++;
        end else begin
          head_q = idx_dec(head_q);
          ring[head_q] = val;
          count_q++;
        end
      end
      dq_pkg::REQ_POP_BACK, dq_pkg::REQ_POP_FRONT: begin
        if (count_q == 0) begin
          r.status = dq_pkg::ST_EMPTY;
          empty_pops++;
        end else begin
          if (req == dq_pkg::REQ_POP_BACK) tail_q = idx_dec(tail_q);
          else head_q = idx_inc(head_q);
          count_q--;
        end
      end
      default: ;
    endcase
    if (count_q != 0) begin
      r.front = ring[head_q];
      r.back  = ring[idx_dec(tail_q)];
    end
    r.fill  = count_q[dq_pkg::FILL_W-1:0];
    r.empty = (count_q == 0);
    if (count_q > peak_fill) peak_fill = count_q;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [dq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // valid stays high across back-to-back words; this task lowers it only for a gap
  task automatic send_word(input logic [dq_pkg::REQ_W-1:0] req,
                           input logic signed [dq_pkg::DATA_W-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic expect_word(input dq_result_t w);
    pending_results.insert(pending_results.size(), w);
  endtask

  task automatic drain_wait();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver side: random stalls, none started while calm
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    dq_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: front %0d back %0d fill %0d",
               front_value_o, back_value_o, fill_count_o);
        mismatch_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (front_value_o !== want.front) begin
          $error("front_value expected %0d actual %0d", want.front, front_value_o);
          mismatch_count++;
        end
        if (back_value_o !== want.back) begin
          $error("back_value expected %0d actual %0d", want.back, back_value_o);
          mismatch_count++;
        end
        if (fill_count_o !== want.fill) begin
          $error("fill_count expected %0d actual %0d", want.fill, fill_count_o);
          mismatch_count++;
        end
        if (is_empty_o !== want.empty) begin
          $error("is_empty expected %0d actual %0d", want.empty, is_empty_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $error("status expected %0d actual %0d", want.status, status_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t                         dir_tab [20];
    dq_result_t                       got;
    traffic_mode_e                    mode;
    logic [dq_pkg::REQ_W-1:0]         req;
    logic signed [dq_pkg::DATA_W-1:0] val;
    int unsigned                      seg_len;
    int unsigned                      n;
    int unsigned                      r;

    dir_tab = '{
      '{dq_pkg::REQ_PEEK, '0, 1'b1,
        '{'0, '0, 7'd0, 1'b1, dq_pkg::ST_DONE}},
      '{dq_pkg::REQ_POP_BACK, '0, 1'b1,
        '{'0, '0, 7'd0, 1'b1, dq_pkg::ST_EMPTY}},
      '{dq_pkg::REQ_POP_FRONT, 32'sd12345, 1'b1,
        '{'0, '0, 7'd0, 1'b1, dq_pkg::ST_EMPTY}},
      '{REQ_UNKNOWN_A, '0, 1'b1,
        '{'0, '0, 7'd0, 1'b1, dq_pkg::ST_DONE}},
      '{dq_pkg::REQ_PUSH_BACK, VAL_MAX, 1'b1,
        '{VAL_MAX, VAL_MAX, 7'd1, 1'b0, dq_pkg::ST_DONE}},
      '{dq_pkg::REQ_PUSH_FRONT, VAL_MIN, 1'b1,
        '{VAL_MIN, VAL_MAX, 7'd2, 1'b0, dq_pkg::ST_DONE}},
      '{dq_pkg::REQ_PEEK, -1, 1'b1,
        '{VAL_MIN, VAL_MAX, 7'd2, 1'b0, dq_pkg::ST_DONE}},
      '{REQ_UNKNOWN_B, '0, 1'b1,
        '{VAL_MIN, VAL_MAX, 7'd2, 1'b0, dq_pkg::ST_DONE}},
      '{REQ_UNKNOWN_C, -1, 1'b1,
        '{VAL_MIN, VAL_MAX, 7'd2, 1'b0, dq_pkg::ST_DONE}},
      '{dq_pkg::REQ_PUSH_BACK,  '0,      1'b0, '0},
      '{dq_pkg::REQ_PUSH_FRONT, -1,      1'b0, '0},
      '{dq_pkg::REQ_POP_BACK,   -1,      1'b0, '0},
      '{dq_pkg::REQ_POP_FRONT,  VAL_MAX, 1'b0, '0},
      '{dq_pkg::REQ_POP_FRONT,  '0,      1'b0, '0},
      '{dq_pkg::REQ_POP_BACK, '0, 1'b1,
        '{'0, '0, 7'd0, 1'b1, dq_pkg::ST_DONE}},
      '{dq_pkg::REQ_POP_BACK, '0, 1'b1,
        '{'0, '0, 7'd0, 1'b1, dq_pkg::ST_EMPTY}},
      '{dq_pkg::REQ_PUSH_BACK,  32'sh55555555, 1'b0, '0},
      '{dq_pkg::REQ_PUSH_FRONT, 32'shaaaaaaaa, 1'b0, '0},
      '{dq_pkg::REQ_POP_FRONT,  '0,            1'b0, '0},
      '{dq_pkg::REQ_PEEK,       '0,            1'b0, '0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].req, dir_tab[i].value);
      got = apply_request(dir_tab[i].req, dir_tab[i].value);
      expect_word(dir_tab[i].typed ? dir_tab[i].want : got);
    end

    // sender holds off until the pipeline is empty
    in_valid_i <= 1'b0;
    drain_wait();

    // segments: fill and drain runs push toward full and empty, the rest is mixed or noise
    n = 0;
    while (n < N_RAND) begin
      r = $urandom_range(0, 99);
      if (r < 35) mode = MODE_FILL;
      else if (r < 70) mode = MODE_DRAIN;
      else if (r < 90) mode = MODE_MIX;
      else mode = MODE_NOISE;
      seg_len = (mode == MODE_FILL || mode == MODE_DRAIN) ? $urandom_range(90, 160)
                                                          : $urandom_range(20, 80);
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < seg_len && n < N_RAND; k++) begin
        r = $urandom_range(0, 99);
        case (mode)
          MODE_FILL:  req = (r < 90) ? dq_pkg::REQ_W'($urandom_range(0, 1))
                                     : dq_pkg::REQ_W'($urandom_range(2, 3));
          MODE_DRAIN: req = (r < 90) ? dq_pkg::REQ_W'($urandom_range(2, 3))
                                     : dq_pkg::REQ_W'($urandom_range(0, 1));
          MODE_MIX:   req = dq_pkg::REQ_W'($urandom_range(0, 4));
          default:    req = dq_pkg::REQ_W'($urandom_range(0, 7));
        endcase
        val = pick_value();
        send_word(req, val);
        expect_word(apply_request(req, val));
        n++;
      end
      if ($urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        drain_wait();
      end
    end

    in_valid_i <= 1'b0;
    calm = 1'b0;
    drain_wait();
    repeat (20) @(posedge clk_i);

    $display("%0d requests sent: %0d pushes dropped on a full queue, %0d pops on an empty one",
             words_sent, full_drops, empty_pops);
    $display("highest fill reached %0d of %0d slots", peak_fill, QDEPTH);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/dq_pkg.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_datapath.sv
hw/rtl/double_ended_queue.sv
hw/rtl/dq_checker.sv
dv/tb.sv
